// ===== sv/fdp_pkg.sv =====
// fdp_pkg: shared widths, register indexes, reset values and struct types
// for the frame deadline pacer; no dependencies
package fdp_pkg;

  localparam int NowW     = 48;
  localparam int CadW     = 20;
  localparam int StaleW   = 8;
  localparam int CntW     = 32;
  localparam int EngW     = 8;
  localparam int ProdW    = CadW + StaleW;
  localparam int ExtW     = NowW + 1;
  localparam int Ext2W    = NowW + 2;
  localparam int DivCntW  = $clog2(NowW);
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  localparam logic [CadW-1:0]   CadenceRst = CadW'(16667);
  localparam logic [CadW-1:0]   MinCadRst  = CadW'(1000);
  localparam logic [CadW-1:0]   MaxCadRst  = CadW'(100000);
  localparam logic [StaleW-1:0] StaleRst   = StaleW'(4);

  localparam logic OpTick = 1'b0;
  localparam logic OpSync = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CADENCE = 3'd0,
    REG_MIN_CAD = 3'd1,
    REG_MAX_CAD = 3'd2,
    REG_STALE   = 3'd3,
    REG_PAUSED  = 3'd4
  } cfg_reg_e;

  // configuration as seen by the sequencer
  typedef struct packed {
    logic [CadW-1:0]   cad;
    logic [StaleW-1:0] stale;
    logic              paused;
  } cfg_view_t;

  typedef struct packed {
    logic              start;
    logic [NowW-1:0]   dividend;
    logic [CadW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [CadW-1:0] rem;
  } div_rsp_t;

  function automatic logic [NowW-1:0] sat48(input logic [Ext2W-1:0] v);
    logic [NowW-1:0] r;
    r = (v[Ext2W-1:NowW] != 2'b00) ? {NowW{1'b1}} : v[NowW-1:0];
    return r;
  endfunction

endpackage

// ===== sv/fdp_in_if.sv =====
// fdp_in_if: input channel of the pacer, valid/ready plus the input word
// depends on fdp_pkg
interface fdp_in_if;
  import fdp_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [EngW-1:0]   engine;
  logic [NowW-1:0]   cur_usec;

  modport source (output valid, operation, engine, cur_usec, input ready);
  modport sink   (input valid, operation, engine, cur_usec, output ready);
endinterface

// ===== sv/fdp_out_if.sv =====
// fdp_out_if: result channel of the pacer, valid/ready plus the result word
// depends on fdp_pkg
interface fdp_out_if;
  import fdp_pkg::*;

  logic              valid;
  logic              ready;
  logic              tick_taken;
  logic [CntW-1:0]   tick_total;
  logic              must_wait;
  logic [NowW-1:0]   wake_usec;

  modport source (output valid, tick_taken, tick_total, must_wait, wake_usec, input ready);
  modport sink   (input valid, tick_taken, tick_total, must_wait, wake_usec, output ready);
endinterface

// ===== sv/frame_deadline_pacer.sv =====
// channel | dir | handshake      | word
// in_i    | in  | valid & ready  | operation, engine, cur_usec
// out_o   | out | valid & ready  | tick_taken, tick_total, must_wait, wake_usec
// cfg     | in  | cfg_we_i       | cfg_idx_i, cfg_wdata_i
//
// a tick goes from idle straight to the output register; a sync passes mul,
// fresh, anchor, decide and out, plus div (the 48 one-bit steps of the serial
// remainder unit) when the deadline is advanced. one item is in work at a time.
// reset clears deadlines, last tick and tick counter at once; no clearing pass.
// a result that is not taken holds the output register and the next item waits.
module frame_deadline_pacer #(
  parameter int ENGINES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fdp_in_if.sink                        in_i,
  fdp_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [fdp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fdp_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import fdp_pkg::*;

  localparam int IdxW = (ENGINES > 1) ? $clog2(ENGINES) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_FRESH  = 3'd2;
  localparam logic [2:0] S_ANCHOR = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  cfg_view_t cfg;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  logic [2:0]      state_q, state_d;
  logic            ovalid_q, ovalid_d;
  logic [CntW-1:0] tick_cnt_q, tick_cnt_d;
  logic [NowW-1:0] vbl_time_q, vbl_time_d;
  logic [NowW-1:0] deadline_q [ENGINES];
  logic            dl_we;
  logic [NowW-1:0] dl_wdata;

  logic [NowW-1:0]  now_q, now_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic             fresh_q, fresh_d;
  logic [NowW-1:0]  dl_q, dl_d;
  logic [ExtW-1:0]  d_q, d_d;
  logic             pend_wait_q, pend_wait_d;
  logic             otaken_q, otaken_d;
  logic [CntW-1:0]  ototal_q, ototal_d;
  logic             owait_q, owait_d;
  logic [NowW-1:0]  owake_q, owake_d;

  logic            in_ready, in_fire, out_free;
  logic [ExtW-1:0] now_x, dl_x, cad_x, cad2_x;
  logic [Ext2W-1:0] d_plus_cad;

  fdp_cfg u_fdp_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  fdp_remdiv u_fdp_remdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_free = !ovalid_q || out_o.ready;
  assign in_ready = (state_q == S_IDLE) && out_free;
  assign in_fire  = in_i.valid && in_ready;

  assign now_x      = {1'b0, now_q};
  assign dl_x       = {1'b0, dl_q};
  assign cad_x      = ExtW'(cfg.cad);
  assign cad2_x     = ExtW'({cfg.cad, 1'b0});
  assign d_plus_cad = {1'b0, d_q} + Ext2W'(cfg.cad);

  always_comb begin
    state_d     = state_q;
    ovalid_d    = ovalid_q && !out_o.ready;
    tick_cnt_d  = tick_cnt_q;
    vbl_time_d  = vbl_time_q;
    dl_we       = 1'b0;
    dl_wdata    = '0;
    now_d       = now_q;
    idx_d       = idx_q;
    prod_d      = prod_q;
    fresh_d     = fresh_q;
    dl_d        = dl_q;
    d_d         = d_q;
    pend_wait_d = pend_wait_q;
    otaken_d    = otaken_q;
    ototal_d    = ototal_q;
    owait_d     = owait_q;
    owake_d     = owake_q;
    div_req.start    = 1'b0;
    div_req.dividend = now_q - d_q[NowW-1:0];
    div_req.divisor  = cfg.cad;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.operation == OpTick) begin
            otaken_d = !cfg.paused;
            ototal_d = cfg.paused ? tick_cnt_q : tick_cnt_q + CntW'(1);
            owait_d  = 1'b0;
            owake_d  = '0;
            ovalid_d = 1'b1;
            if (!cfg.paused) begin
              tick_cnt_d = tick_cnt_q + CntW'(1);
              vbl_time_d = in_i.cur_usec;
            end
          end else begin
            now_d   = in_i.cur_usec;
            // engines past the end fold onto engine 0
            idx_d   = (in_i.engine < EngW'(ENGINES)) ? in_i.engine[IdxW-1:0] : '0;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_d  = ProdW'(cfg.cad) * ProdW'(cfg.stale);
        dl_d    = deadline_q[idx_q];
        state_d = S_FRESH;
      end
      S_FRESH: begin
        fresh_d = (vbl_time_q != '0) && (now_x <= ({1'b0, vbl_time_q} + ExtW'(prod_q)));
        state_d = S_ANCHOR;
      end
      S_ANCHOR: begin
        if (fresh_q) begin
          if (dl_q == '0 || dl_x > ({1'b0, vbl_time_q} + cad2_x)) begin
            d_d = {1'b0, vbl_time_q} + cad_x;
          end else begin
            d_d = dl_x;
          end
        end else begin
          if (dl_q == '0 || dl_q <= now_q ||
              {1'b0, dl_x} > ({1'b0, now_x} + Ext2W'(cad2_x))) begin
            d_d = now_x + cad_x;
          end else begin
            d_d = dl_x;
          end
        end
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (fresh_q && d_q <= now_x) begin
          // boundary passed: next grid point is now + cad - (now - d) mod cad
          div_req.start = 1'b1;
          pend_wait_d   = 1'b0;
          state_d       = S_DIV;
        end else begin
          pend_wait_d = 1'b1;
          state_d     = S_OUT;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          d_d     = now_x + cad_x - ExtW'(div_rsp.rem);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          dl_we    = 1'b1;
          dl_wdata = pend_wait_q ? sat48(d_plus_cad) : sat48({1'b0, d_q});
          otaken_d = 1'b0;
          ototal_d = tick_cnt_q;
          owait_d  = pend_wait_q;
          owake_d  = pend_wait_q ? sat48({1'b0, d_q}) : '0;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ovalid_q   <= 1'b0;
      tick_cnt_q <= '0;
      vbl_time_q <= '0;
      for (int i = 0; i < ENGINES; i++) begin
        deadline_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      ovalid_q   <= ovalid_d;
      tick_cnt_q <= tick_cnt_d;
      vbl_time_q <= vbl_time_d;
      if (dl_we) begin
        deadline_q[idx_q] <= dl_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q       <= now_d;
    idx_q       <= idx_d;
    prod_q      <= prod_d;
    fresh_q     <= fresh_d;
    dl_q        <= dl_d;
    d_q         <= d_d;
    pend_wait_q <= pend_wait_d;
    otaken_q    <= otaken_d;
    ototal_q    <= ototal_d;
    owait_q     <= owait_d;
    owake_q     <= owake_d;
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = ovalid_q;
  assign out_o.tick_taken = otaken_q;
  assign out_o.tick_total = ototal_q;
  assign out_o.must_wait  = owait_q;
  assign out_o.wake_usec  = owake_q;

endmodule

// ===== sv/fdp_cfg.sv =====
// fdp_cfg: configuration register bank and cadence clamp
// depends on fdp_pkg
module fdp_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [fdp_pkg::CfgIdxW-1:0]   idx_i,
  input  logic [fdp_pkg::CfgDataW-1:0]  wdata_i,
  output fdp_pkg::cfg_view_t            cfg_o
);
  import fdp_pkg::*;

  logic [CadW-1:0]   cadence_q, min_cad_q, max_cad_q;
  logic [StaleW-1:0] stale_q;
  logic              paused_q;
  logic [CadW-1:0]   cad_lo, cad_hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cadence_q <= CadenceRst;
      min_cad_q <= MinCadRst;
      max_cad_q <= MaxCadRst;
      stale_q   <= StaleRst;
      paused_q  <= 1'b0;
    end else if (we_i) begin
      unique case (idx_i)
        REG_CADENCE: cadence_q <= wdata_i[CadW-1:0];
        REG_MIN_CAD: min_cad_q <= wdata_i[CadW-1:0];
        REG_MAX_CAD: max_cad_q <= wdata_i[CadW-1:0];
        REG_STALE:   stale_q   <= wdata_i[StaleW-1:0];
        REG_PAUSED:  paused_q  <= wdata_i[0];
        default: ;
      endcase
    end
  end

  // min first, then max, so max wins on crossed bounds; zero becomes one
  always_comb begin
    cad_lo = (cadence_q < min_cad_q) ? min_cad_q : cadence_q;
    cad_hi = (cad_lo > max_cad_q) ? max_cad_q : cad_lo;
    cfg_o.cad    = (cad_hi == '0) ? CadW'(1) : cad_hi;
    cfg_o.stale  = stale_q;
    cfg_o.paused = paused_q;
  end

endmodule

// ===== sv/fdp_remdiv.sv =====
// fdp_remdiv: bit-serial restoring remainder unit, one dividend bit per cycle
// depends on fdp_pkg
module fdp_remdiv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fdp_pkg::div_req_t  req_i,
  output fdp_pkg::div_rsp_t  rsp_o
);
  import fdp_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [NowW-1:0]    dvd_q, dvd_d;
  logic [CadW-1:0]    rem_q, rem_d;
  logic [CadW-1:0]    dsr_q, dsr_d;
  logic [CadW:0]      trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    trial  = {rem_q, dvd_q[NowW-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      rem_d = (trial >= {1'b0, dsr_q}) ? CadW'(trial - {1'b0, dsr_q}) : trial[CadW-1:0];
      dvd_d = {dvd_q[NowW-2:0], 1'b0};
      cnt_d = cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(NowW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== sv/fdp_checker.sv =====
// fdp_checker: port-level assertions on the pacer result channel, with bind
// depends on fdp_pkg and frame_deadline_pacer
module fdp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        tick_taken_i,
  input logic [fdp_pkg::CntW-1:0]    tick_total_i,
  input logic                        must_wait_i,
  input logic [fdp_pkg::NowW-1:0]    wake_usec_i
);
  import fdp_pkg::*;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(tick_taken_i) && $stable(tick_total_i)
      && $stable(must_wait_i) && $stable(wake_usec_i))
    else $error("result word changed while stalled");

  a_tick_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && tick_taken_i |-> !must_wait_i)
    else $error("counted tick reports a wait");

  a_no_wait_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !must_wait_i |-> wake_usec_i == '0)
    else $error("wake time set without a wait");

  a_wait_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && must_wait_i |-> wake_usec_i != '0)
    else $error("wait reported with zero wake time");

endmodule

bind frame_deadline_pacer fdp_checker u_fdp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .tick_taken_i (out_o.tick_taken),
  .tick_total_i (out_o.tick_total),
  .must_wait_i  (out_o.must_wait),
  .wake_usec_i  (out_o.wake_usec)
);
